### src/des_round_key_generator_core_macros.svh
// Assertion macros for the DES round key generator.
// Depends on nothing; included by the top level for its checks.
`ifndef DES_ROUND_KEY_GENERATOR_CORE_MACROS_SVH
`define DES_ROUND_KEY_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define RKG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define RKG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/des_rkg_pkg.sv
// Package for the DES round key generator: PC-1 / PC-2 tables, rotation
// schedule and the permutation and rotation helpers. No dependencies.
package des_rkg_pkg;

    localparam int unsigned HALF_BITS   = 28;
    localparam int unsigned CD_BITS     = 56;
    localparam int unsigned KEY_BITS    = 64;
    localparam int unsigned SUBKEY_BITS = 48;
    localparam int unsigned ROUNDS      = 16;
    localparam int unsigned ROUND_BITS  = $clog2(ROUNDS);

    // Register map (index = byte address / 4)
    localparam logic REG_REVERSE_ORDER = 1'b0;

    // Bit k set where round k rotates by two places, else by one
    localparam logic [ROUNDS-1:0] ROT_TWO = 16'h7EFC;

    localparam int unsigned PC1_TAB [CD_BITS] = '{
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4};

    localparam int unsigned PC2_TAB [SUBKEY_BITS] = '{
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};

    typedef logic [HALF_BITS-1:0]   t_half;
    typedef logic [CD_BITS-1:0]     t_cd;
    typedef logic [KEY_BITS-1:0]    t_key;
    typedef logic [SUBKEY_BITS-1:0] t_subkey;
    typedef logic [ROUND_BITS-1:0]  t_round;

    // PC-1: DES bit 1 is the MSB of both key and result; parity bits drop out
    function automatic t_cd pc1(input t_key key);
        t_cd cd;
        for (int i = 0; i < CD_BITS; i++) begin
            cd[CD_BITS-1-i] = key[KEY_BITS-PC1_TAB[i]];
        end
        return cd;
    endfunction

    // PC-2 over the joined halves C:D
    function automatic t_subkey pc2(input t_half c, input t_half d);
        t_cd     cd;
        t_subkey sk;
        cd = {c, d};
        for (int i = 0; i < SUBKEY_BITS; i++) begin
            sk[SUBKEY_BITS-1-i] = cd[CD_BITS-PC2_TAB[i]];
        end
        return sk;
    endfunction

    function automatic t_half rotl28(input t_half x, input logic two);
        return two ? {x[HALF_BITS-3:0], x[HALF_BITS-1:HALF_BITS-2]}
                   : {x[HALF_BITS-2:0], x[HALF_BITS-1]};
    endfunction

    function automatic t_half rotr28(input t_half x, input logic two);
        return two ? {x[1:0], x[HALF_BITS-1:2]}
                   : {x[0], x[HALF_BITS-1:1]};
    endfunction

endpackage

### src/des_rkg_key_if.sv
// Key request channel of the DES round key generator.
// Depends on des_rkg_pkg for the key type.
interface des_rkg_key_if
    import des_rkg_pkg::*;
;
    logic valid;
    logic ready;
    t_key key_in;

    modport source (output valid, output key_in, input ready);
    modport sink   (input valid, input key_in, output ready);
endinterface

### src/des_rkg_sk_if.sv
// Subkey request channel of the DES round key generator.
// Depends on des_rkg_pkg for the round and subkey types.
interface des_rkg_sk_if
    import des_rkg_pkg::*;
;
    logic    valid;
    logic    ready;
    t_round  round_index;
    t_subkey subkey;
    logic    last;

    modport source (output valid, output round_index, output subkey, output last, input ready);
    modport sink   (input valid, input round_index, input subkey, input last, output ready);
endinterface

### src/des_round_key_generator_core.sv
// DES key schedule: one key request in, sixteen 48-bit subkey requests out.
// A taken key loads the halves; the first subkey enters the output register when round 1 issues.
// Throughput: one subkey per cycle while the output is not stalled; the next key is taken
// in the cycle that issues round 16 of the current one, so rounds run without a gap.
// Reset (synchronous, active low) clears the round state, the output valid and
// reverse_order; the halves and the output payload are not reset.
`include "des_round_key_generator_core_macros.svh"

module des_round_key_generator_core
    import des_rkg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    des_rkg_key_if.sink       i_key,
    des_rkg_sk_if.source      o_subkey,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic    r_reverse;
    logic    r_busy,  n_busy;
    t_round  r_cnt,   n_cnt;
    t_half   r_c,     n_c;
    t_half   r_d,     n_d;
    logic    r_out_valid, n_out_valid;
    t_round  r_round_index, n_round_index;
    t_subkey r_subkey, n_subkey;
    logic    r_last,   n_last;

    logic    out_free;
    logic    issue;
    logic    key_take;
    logic    two;
    t_half   c_fwd, d_fwd;
    t_cd     cd_key;

    // Configuration port: one register, writes only in the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REVERSE_ORDER) ? {31'd0, r_reverse} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_REVERSE_ORDER) begin
            r_reverse <= pwdata[0];
        end
    end

    // Handshake: the output register frees when empty or drained this cycle
    assign out_free = !r_out_valid || o_subkey.ready;
    assign issue    = r_busy && out_free;
    assign i_key.ready = !r_busy || (issue && r_cnt == t_round'(ROUNDS - 1));
    assign key_take = i_key.valid && i_key.ready;

    // Round step: forward rotates left then permutes; reverse permutes then
    // rotates right, starting from the PC-1 halves (a full 28-place turn)
    assign two    = r_reverse ? ROT_TWO[~r_cnt] : ROT_TWO[r_cnt];
    assign c_fwd  = rotl28(r_c, two);
    assign d_fwd  = rotl28(r_d, two);
    assign cd_key = pc1(i_key.key_in);

    always_comb begin
        n_busy        = r_busy;
        n_cnt         = r_cnt;
        n_c           = r_c;
        n_d           = r_d;
        n_out_valid   = r_out_valid && !o_subkey.ready;
        n_round_index = r_round_index;
        n_subkey      = r_subkey;
        n_last        = r_last;

        if (issue) begin
            n_out_valid   = 1'b1;
            n_round_index = r_cnt;
            n_last        = (r_cnt == t_round'(ROUNDS - 1));
            n_cnt         = r_cnt + t_round'(1);
            if (r_cnt == t_round'(ROUNDS - 1)) begin
                n_busy = 1'b0;
            end
            if (r_reverse) begin
                n_subkey = pc2(r_c, r_d);
                n_c      = rotr28(r_c, two);
                n_d      = rotr28(r_d, two);
            end else begin
                n_subkey = pc2(c_fwd, d_fwd);
                n_c      = c_fwd;
                n_d      = d_fwd;
            end
        end

        if (key_take) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_c    = cd_key[CD_BITS-1:HALF_BITS];
            n_d    = cd_key[HALF_BITS-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Halves and output payload
    always_ff @(posedge i_clk) begin
        r_c           <= n_c;
        r_d           <= n_d;
        r_round_index <= n_round_index;
        r_subkey      <= n_subkey;
        r_last        <= n_last;
    end

    assign o_subkey.valid       = r_out_valid;
    assign o_subkey.round_index = r_round_index;
    assign o_subkey.subkey      = r_subkey;
    assign o_subkey.last        = r_last;

    // Checks
    `RKG_ASSERT_NEXT(a_key_starts_round0, i_clk, i_rst_n, key_take, r_busy && r_cnt == '0, "key taken but round state not restarted")
    `RKG_ASSERT_NEXT(a_issue_fills_out, i_clk, i_rst_n, issue, r_out_valid, "round issued but output register empty")
    `RKG_ASSERT_NOW(a_last_on_round16, i_clk, i_rst_n, r_out_valid, r_last == (r_round_index == t_round'(ROUNDS - 1)), "last flag disagrees with round index")

endmodule

### tb/des_round_key_generator_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for des_round_key_generator_core: drives key requests, APB writes and
// reads, predicts all sixteen subkeys per key and checks them. Depends on des_rkg_pkg and the
// key and subkey channel interfaces.
module des_round_key_generator_core_test
    import des_rkg_pkg::*;
;

    // APB byte addresses: the single register and a hole past the end of the map
    localparam logic [2:0] ADDR_REVERSE_ORDER = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;

    // Standard DES key schedule tables, DES bit 1 = MSB
    localparam int KS_PC1 [56] = '{
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4};
    localparam int KS_PC2 [48] = '{
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};
    localparam int KS_SHIFT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    // Directed keys: extremes, the textbook keys, a weak key, parity-only, alternating and single bits
    localparam t_key CORNER_KEYS [9] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1334_5779_9BBC_DFF1,
        64'h0123_4567_89AB_CDEF, 64'hFEFE_FEFE_FEFE_FEFE, 64'h0101_0101_0101_0101,
        64'hAAAA_5555_AAAA_5555, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};

    // Holds the subkeys still owed by the block and works them out per key
    class subkey_ledger;
        typedef struct {
            t_round  idx;
            t_subkey sk;
            logic    fin;
        } t_due;

        t_due due_subkeys[$];
        bit   reverse;
        int   errors;

        function new();
            reverse = 1'b0;
            errors  = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return due_subkeys.size();
        endfunction

        function t_subkey choose_bits(input t_half c, input t_half d);
            logic [55:0] cd;
            t_subkey     sk;
            cd = {c, d};
            for (int i = 0; i < 48; i++) begin
                sk[47-i] = cd[56-KS_PC2[i]];
            end
            return sk;
        endfunction

        // Predict the sixteen subkeys of an accepted key in the current order
        function void take_key(input t_key k);
            logic [55:0] cd;
            t_half       c;
            t_half       d;
            t_due        e;
            for (int i = 0; i < 56; i++) begin
                cd[55-i] = k[64-KS_PC1[i]];
            end
            c = cd[55:28];
            d = cd[27:0];
            for (int r = 0; r < 16; r++) begin
                if (reverse) begin
                    // round 16 halves equal the PC-1 halves; step back by turning right
                    e.sk = choose_bits(c, d);
                    repeat (KS_SHIFT[15-r]) begin
                        c = {c[0], c[27:1]};
                        d = {d[0], d[27:1]};
                    end
                end else begin
                    repeat (KS_SHIFT[r]) begin
                        c = {c[26:0], c[27]};
                        d = {d[26:0], d[27]};
                    end
                    e.sk = choose_bits(c, d);
                end
                e.idx = t_round'(r);
                e.fin = (r == 15);
                due_subkeys.push_back(e);
            end
        endfunction

        task match_subkey(input t_round idx, input t_subkey sk, input logic fin);
            t_due e;
            if (due_subkeys.size() == 0) begin
                report($sformatf("subkey %h (round %0d) with none outstanding", sk, idx));
                return;
            end
            e = due_subkeys.pop_front();
            if (idx !== e.idx)
                report($sformatf("round_index %0d, wanted %0d", idx, e.idx));
            if (sk !== e.sk)
                report($sformatf("subkey %h, wanted %h (round %0d)", sk, e.sk, e.idx));
            if (fin !== e.fin)
                report($sformatf("last %b, wanted %b (round %0d)", fin, e.fin, e.idx));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    subkey_ledger ledger;

    des_rkg_key_if key_ch();
    des_rkg_sk_if  sk_ch();

    des_round_key_generator_core dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_key    (key_ch),
        .o_subkey (sk_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Subkey sink: random back-pressure, results checked at the rising edge
    initial begin
        int stall;
        stall = 0;
        sk_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                sk_ch.ready <= 1'b0;
                stall--;
            end else begin
                sk_ch.ready <= 1'b1;
                stall = pick_gap(rx_calm);
            end
            @(posedge clk);
            if (rst_n && sk_ch.valid === 1'b1 && sk_ch.ready)
                ledger.match_subkey(sk_ch.round_index, sk_ch.subkey, sk_ch.last);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_key(input t_key k);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            key_ch.valid  <= 1'b0;
            key_ch.key_in <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        key_ch.valid  <= 1'b1;
        key_ch.key_in <= k;
        do @(posedge clk); while (key_ch.ready !== 1'b1);
        ledger.take_key(k);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (ledger.pending() != 0) @(negedge clk);
    endtask

    // APB write, only once the block has gone idle
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        key_ch.valid <= 1'b0;
        wait_drained();
        repeat (3) @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (addr == ADDR_REVERSE_ORDER)
            ledger.reverse = data[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read of the order bit, compared with the bench's copy
    task automatic cfg_check();
        // leave the bus idle between transfers
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_REVERSE_ORDER;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata[0] !== ledger.reverse)
            ledger.report($sformatf("reverse_order reads %b, wanted %b",
                                    prdata[0], ledger.reverse));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stimulus
    initial begin
        ledger         = new();
        rst_n          = 1'b0;
        key_ch.valid   = 1'b0;
        key_ch.key_in  = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed keys in reset order, then reversed
        cfg_check();
        foreach (CORNER_KEYS[i]) send_key(CORNER_KEYS[i]);
        cfg_write(ADDR_REVERSE_ORDER, 32'h0000_0001);
        cfg_check();
        foreach (CORNER_KEYS[i]) send_key(CORNER_KEYS[i]);

        // unmapped address is ignored; only bit 0 of the value counts
        cfg_write(ADDR_UNMAPPED, 32'h0000_0000);
        cfg_check();
        send_key(64'h0E32_9232_EA6D_0D73);
        cfg_write(ADDR_REVERSE_ORDER, 32'hFFFF_FFFE);
        cfg_check();
        send_key(64'h0E32_9232_EA6D_0D73);

        // random keys over several settings, one calm phase, one drain pause
        for (int ph = 0; ph < 7; ph++) begin
            cfg_write(ADDR_REVERSE_ORDER, {31'($urandom_range(0, 32'h7FFF_FFFF)), ph[0]});
            if (ph == 3)
                cfg_write(ADDR_UNMAPPED, $urandom);
            tx_calm = (ph == 2);
            rx_calm = (ph == 2);
            for (int n = 0; n < 40; n++) begin
                if (ph == 4 && n == 20) begin
                    key_ch.valid <= 1'b0;
                    wait_drained();
                    @(negedge clk);
                end
                send_key({$urandom, $urandom});
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        key_ch.valid <= 1'b0;
        wait_drained();
        repeat (20) @(negedge clk);
        if (ledger.errors == 0)
            $display("des_round_key_generator_core_test OK");
        else
            $display("des_round_key_generator_core_test NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #(8_000_000);
        $display("timeout waiting for subkey requests");
        $display("des_round_key_generator_core_test NOT OK");
        $finish;
    end

endmodule
